>>> hw/rtl/pair_table_interpolator_macros.svh
// Assertion macros shared by the pair table interpolator RTL.
// The asserting module must have clk_i and rst_ni in scope.
`ifndef PAIR_TABLE_INTERPOLATOR_MACROS_SVH
`define PAIR_TABLE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PTI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PTI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pti_pkg.sv
package pti_pkg;

  // Default table dimensions.
  localparam int unsigned MAX_TYPES  = 8;
  localparam int unsigned MAX_VALUES = 256;

  // Field widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIST_W    = 32;
  localparam int unsigned TYPE_W    = 3;
  localparam int unsigned WIDX_W    = 14;
  localparam int unsigned NTYPES_W  = 4;
  localparam int unsigned NVALUES_W = 9;
  localparam int unsigned STEP_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [NTYPES_W-1:0]  NUM_TYPES_RST  = 4'd8;
  localparam logic [NVALUES_W-1:0] NUM_VALUES_RST = 9'd256;
  localparam logic [STEP_W-1:0]    STEP_RECIP_RST = 32'd65536;

  // Item function and table select codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
  localparam logic TBL_POT    = 1'b0;
  localparam logic TBL_FORCE  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_TYPES  = 2'd0,
    CFG_NUM_VALUES = 2'd1,
    CFG_STEP_RECIP = 2'd2
  } cfg_idx_e;

  // Control carried along the pipeline with each item.
  typedef struct packed {
    logic              valid;
    logic              query;
    logic              sel;
    logic              beyond;
    logic              wr_en;
    logic [FRAC_W-1:0] frac;
  } stage_ctl_t;

endpackage

>>> hw/rtl/pair_table_interpolator.sv
// Channel    Direction  Handshake                  Payload
// in         input      in_valid_i / in_ready_o    func, table_select, type_a, type_b,
//                                                  distance, write_index, write_value
// out        output     out_valid_o / out_ready_i  value, beyond_table
// cfg        input      cfg_valid_i / cfg_ready_o  cfg_index, cfg_data
//
// Five register stages: product and pair row, bound check and base address, table
// read, slope multiply, round and saturate. One item per cycle unless a stall backs
// up to the input; a query gives a result from stage 5, a write item gives no result.
// Each stage loads when it is empty or its item moves on, so stalls only back up
// through full stages. Reset clears valid bits and config registers; tables need none.
// The configuration port is always ready and takes a write every cycle.
`include "pair_table_interpolator_macros.svh"

module pair_table_interpolator #(
  parameter int unsigned MaxTypes  = pti_pkg::MAX_TYPES,
  parameter int unsigned MaxValues = pti_pkg::MAX_VALUES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  logic                               table_select_i,
  input  logic [pti_pkg::TYPE_W-1:0]         type_a_i,
  input  logic [pti_pkg::TYPE_W-1:0]         type_b_i,
  input  logic [pti_pkg::DIST_W-1:0]         distance_i,
  input  logic [pti_pkg::WIDX_W-1:0]         write_index_i,
  input  logic signed [pti_pkg::DATA_W-1:0]  write_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pti_pkg::DATA_W-1:0]  value_o,
  output logic                               beyond_table_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pti_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pti_pkg::DATA_W-1:0]         cfg_data_i
);

  import pti_pkg::*;

  localparam int unsigned TableDepth = MaxTypes * (MaxTypes + 1) / 2 * MaxValues;
  localparam int unsigned AddrW      = $clog2(TableDepth);

  logic [NTYPES_W-1:0]      num_types_q;
  logic [NVALUES_W-1:0]     num_values_q;
  logic [STEP_W-1:0]        step_recip_q;

  stage_ctl_t               ctl2;
  stage_ctl_t               ctl3_d;
  stage_ctl_t               ctl3_q;
  logic [AddrW-1:0]         rd_addr;
  logic [AddrW-1:0]         rd_addr1;
  logic [AddrW-1:0]         wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     en3;
  logic                     interp_ready;
  logic                     rd_en;
  logic                     wr_en;
  logic                     re_pot;
  logic                     re_frc;
  logic                     we_pot;
  logic                     we_frc;
  logic [DATA_W-1:0]        pot_y0;
  logic [DATA_W-1:0]        pot_y1;
  logic [DATA_W-1:0]        frc_y0;
  logic [DATA_W-1:0]        frc_y1;
  logic signed [DATA_W-1:0] y0;
  logic signed [DATA_W-1:0] y1;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_types_q  <= NUM_TYPES_RST;
      num_values_q <= NUM_VALUES_RST;
      step_recip_q <= STEP_RECIP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_TYPES:  num_types_q  <= cfg_data_i[NTYPES_W-1:0];
        CFG_NUM_VALUES: num_values_q <= cfg_data_i[NVALUES_W-1:0];
        CFG_STEP_RECIP: step_recip_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stages 1 and 2: index, fraction and table address.
  pti_addr #(
    .MaxTypes (MaxTypes),
    .MaxValues(MaxValues),
    .AddrW    (AddrW)
  ) u_addr (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .table_select_i,
    .type_a_i,
    .type_b_i,
    .distance_i,
    .write_index_i,
    .write_value_i,
    .num_types_i (num_types_q),
    .num_values_i(num_values_q),
    .step_recip_i(step_recip_q),
    .ctl_o       (ctl2),
    .out_ready_i (en3),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // Table access: a write lands entering stage 3; an in-table query reads both samples.
  assign en3      = !ctl3_q.valid || interp_ready;
  assign rd_addr1 = rd_addr + AddrW'(1);
  assign rd_en    = en3 && ctl2.valid && ctl2.query && !ctl2.beyond;
  assign wr_en    = en3 && ctl2.valid && !ctl2.query && ctl2.wr_en;
  assign re_pot   = rd_en && (ctl2.sel == TBL_POT);
  assign re_frc   = rd_en && (ctl2.sel == TBL_FORCE);
  assign we_pot   = wr_en && (ctl2.sel == TBL_POT);
  assign we_frc   = wr_en && (ctl2.sel == TBL_FORCE);

  pti_ram #(
    .Width(DATA_W),
    .Depth(TableDepth)
  ) u_pot_ram (
    .clk_i,
    .we_i     (we_pot),
    .waddr_i  (wr_addr),
    .wdata_i  (wr_data),
    .re_i     (re_pot),
    .raddr_a_i(rd_addr),
    .raddr_b_i(rd_addr1),
    .rdata_a_o(pot_y0),
    .rdata_b_o(pot_y1)
  );

  pti_ram #(
    .Width(DATA_W),
    .Depth(TableDepth)
  ) u_frc_ram (
    .clk_i,
    .we_i     (we_frc),
    .waddr_i  (wr_addr),
    .wdata_i  (wr_data),
    .re_i     (re_frc),
    .raddr_a_i(rd_addr),
    .raddr_b_i(rd_addr1),
    .rdata_a_o(frc_y0),
    .rdata_b_o(frc_y1)
  );

  // Stage 3 control; write items end here.
  always_comb begin
    ctl3_d       = ctl2;
    ctl3_d.valid = ctl2.valid && ctl2.query;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (en3) begin
      ctl3_q <= ctl3_d;
    end
  end

  assign y0 = $signed((ctl3_q.sel == TBL_FORCE) ? frc_y0 : pot_y0);
  assign y1 = $signed((ctl3_q.sel == TBL_FORCE) ? frc_y1 : pot_y1);

  // Stages 4 and 5: interpolation and output register.
  pti_interp u_interp (
    .clk_i,
    .rst_ni,
    .ctl_i         (ctl3_q),
    .ready_o       (interp_ready),
    .y0_i          (y0),
    .y1_i          (y1),
    .out_valid_o,
    .out_ready_i,
    .value_o,
    .beyond_table_o
  );

  // A table is never written and read in the same cycle.
  `PTI_ASSERT_IMP(a_no_rw_clash, wr_en, !rd_en, "table write and read in one cycle")
  // A stalled query in stage 3 keeps its read samples.
  `PTI_ASSERT_NXT(a_s3_hold, ctl3_q.valid && !ctl3_q.beyond && !en3,
                  $stable(y0) && $stable(y1), "stalled samples changed")
  // Input backs up only when the output is stalled.
  `PTI_ASSERT_IMP(a_backpressure, !in_ready_o, out_valid_o && !out_ready_i,
                  "input stalled without output stall")
  // A result past the table carries zero.
  `PTI_ASSERT_IMP(a_beyond_zero, out_valid_o && beyond_table_o, value_o == '0,
                  "nonzero value past table")

endmodule

>>> hw/rtl/pti_ram.sv
module pti_ram #(
  parameter int unsigned Width = pti_pkg::DATA_W,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hw/rtl/pti_addr.sv
module pti_addr #(
  parameter int unsigned MaxTypes  = pti_pkg::MAX_TYPES,
  parameter int unsigned MaxValues = pti_pkg::MAX_VALUES,
  parameter int unsigned AddrW     = $clog2(MaxTypes * (MaxTypes + 1) / 2 * MaxValues)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic                              table_select_i,
  input  logic [pti_pkg::TYPE_W-1:0]        type_a_i,
  input  logic [pti_pkg::TYPE_W-1:0]        type_b_i,
  input  logic [pti_pkg::DIST_W-1:0]        distance_i,
  input  logic [pti_pkg::WIDX_W-1:0]        write_index_i,
  input  logic signed [pti_pkg::DATA_W-1:0] write_value_i,
  input  logic [pti_pkg::NTYPES_W-1:0]      num_types_i,
  input  logic [pti_pkg::NVALUES_W-1:0]     num_values_i,
  input  logic [pti_pkg::STEP_W-1:0]        step_recip_i,
  output pti_pkg::stage_ctl_t               ctl_o,
  input  logic                              out_ready_i,
  output logic [AddrW-1:0]                  rd_addr_o,
  output logic [AddrW-1:0]                  wr_addr_o,
  output logic signed [pti_pkg::DATA_W-1:0] wr_data_o
);

  import pti_pkg::*;

  localparam int unsigned NumPairs   = MaxTypes * (MaxTypes + 1) / 2;
  localparam int unsigned TableDepth = NumPairs * MaxValues;
  localparam int unsigned TW         = $clog2(MaxTypes + 1);
  localparam int unsigned CW         = $clog2(MaxValues + 1);
  localparam int unsigned IW         = $clog2(MaxValues);
  localparam int unsigned PW         = $clog2(NumPairs + 1);
  localparam int unsigned MW         = TW + TYPE_W + 2;
  localparam int unsigned BW         = PW + CW;
  localparam int unsigned PROD_W     = DIST_W + STEP_W;

  // Stage 1 registers.
  logic                     v1_q;
  logic                     query1_q;
  logic                     sel1_q;
  logic                     type_ok1_q;
  logic                     wr_ok1_q;
  logic [PW-1:0]            pair1_q;
  logic [PROD_W-1:0]        prod1_q;
  logic [WIDX_W-1:0]        widx1_q;
  logic signed [DATA_W-1:0] wval1_q;

  // Stage 2 registers.
  logic                     v2_q;
  logic                     query2_q;
  logic                     sel2_q;
  logic                     beyond2_q;
  logic                     wr_ok2_q;
  logic [FRAC_W-1:0]        frac2_q;
  logic [AddrW-1:0]         base2_q;
  logic [IW-1:0]            idx2_q;
  logic [AddrW-1:0]         waddr2_q;
  logic signed [DATA_W-1:0] wval2_q;

  logic [TW-1:0]            t_clamp;
  logic [CW-1:0]            n_clamp;
  logic [TYPE_W-1:0]        lo;
  logic [TYPE_W-1:0]        hi;
  logic [MW-1:0]            tri_prod;
  logic [PW-1:0]            pair_d;
  logic [PROD_W-1:0]        prod_d;
  logic                     type_ok_d;
  logic                     wr_ok_d;
  logic                     idx_ok;
  logic                     beyond_d;
  logic [BW-1:0]            base_d;
  logic                     en1;
  logic                     en2;

  // Clamp the table shape registers into the supported range.
  always_comb begin
    if (num_types_i == '0) begin
      t_clamp = TW'(1);
    end else if (32'(num_types_i) > 32'(MaxTypes)) begin
      t_clamp = TW'(MaxTypes);
    end else begin
      t_clamp = TW'(num_types_i);
    end
    if (32'(num_values_i) < 32'(2)) begin
      n_clamp = CW'(2);
    end else if (32'(num_values_i) > 32'(MaxValues)) begin
      n_clamp = CW'(MaxValues);
    end else begin
      n_clamp = CW'(num_values_i);
    end
  end

  // Order the types and find the upper-triangular pair row.
  assign lo        = (type_a_i < type_b_i) ? type_a_i : type_b_i;
  assign hi        = (type_a_i < type_b_i) ? type_b_i : type_a_i;
  assign tri_prod  = MW'(lo) * (MW'({t_clamp, 1'b0}) + MW'(1) - MW'(lo));
  assign pair_d    = PW'((tri_prod >> 1) + MW'(hi - lo));
  assign type_ok_d = 32'(hi) < 32'(t_clamp);
  assign wr_ok_d   = 32'(write_index_i) < 32'(TableDepth);

  // Distance times reciprocal step, an exact Q32.32 product.
  assign prod_d = PROD_W'(distance_i) * PROD_W'(step_recip_i);

  // Stage 2: bound check on the sample index and the pair base address.
  assign idx_ok   = ({1'b0, prod1_q[PROD_W-1:DIST_W]} + 33'd1) < 33'(n_clamp);
  assign beyond_d = !(type_ok1_q && idx_ok);
  assign base_d   = BW'(pair1_q) * BW'(n_clamp);

  // Per-stage enables: a stage loads when it is empty or its item moves on.
  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      query1_q   <= (func_i == FUNC_QUERY);
      sel1_q     <= table_select_i;
      type_ok1_q <= type_ok_d;
      wr_ok1_q   <= wr_ok_d;
      pair1_q    <= pair_d;
      prod1_q    <= prod_d;
      widx1_q    <= write_index_i;
      wval1_q    <= write_value_i;
    end
    if (en2 && v1_q) begin
      query2_q  <= query1_q;
      sel2_q    <= sel1_q;
      beyond2_q <= beyond_d;
      wr_ok2_q  <= wr_ok1_q;
      frac2_q   <= prod1_q[DIST_W-1:DIST_W-FRAC_W];
      base2_q   <= AddrW'(base_d);
      idx2_q    <= prod1_q[DIST_W +: IW];
      waddr2_q  <= AddrW'(widx1_q);
      wval2_q   <= wval1_q;
    end
  end

  // Memory stage requests.
  assign ctl_o = '{valid: v2_q, query: query2_q, sel: sel2_q, beyond: beyond2_q,
                   wr_en: wr_ok2_q, frac: frac2_q};
  assign rd_addr_o = base2_q + AddrW'(idx2_q);
  assign wr_addr_o = waddr2_q;
  assign wr_data_o = wval2_q;

endmodule

>>> hw/rtl/pti_interp.sv
module pti_interp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pti_pkg::stage_ctl_t               ctl_i,
  output logic                              ready_o,
  input  logic signed [pti_pkg::DATA_W-1:0] y0_i,
  input  logic signed [pti_pkg::DATA_W-1:0] y1_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pti_pkg::DATA_W-1:0] value_o,
  output logic                              beyond_table_o
);

  import pti_pkg::*;

  localparam int unsigned DIFF_W = DATA_W + 1;
  localparam int unsigned PROD_W = DIFF_W + FRAC_W + 1;
  localparam int unsigned SUM_W  = PROD_W - FRAC_W;
  localparam int unsigned RES_W  = SUM_W + 1;
  localparam logic signed [PROD_W-1:0] Half = PROD_W'(2 ** (FRAC_W - 1));

  logic                     v4_q;
  logic                     beyond4_q;
  logic signed [PROD_W-1:0] prod4_q;
  logic signed [DATA_W-1:0] y0_4_q;
  logic                     v5_q;
  logic                     beyond5_q;
  logic signed [DATA_W-1:0] value5_q;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] rounded;
  logic signed [SUM_W-1:0]  step;
  logic signed [RES_W-1:0]  res;
  logic signed [DATA_W-1:0] value_d;
  logic                     en4;
  logic                     en5;

  // Stage 4: slope times fraction.
  assign diff   = DIFF_W'(y1_i) - DIFF_W'(y0_i);
  assign prod_d = PROD_W'(diff) * PROD_W'($signed({1'b0, ctl_i.frac}));

  // Stage 5: round to nearest, ties upward, add the base sample, saturate; zero if beyond.
  assign rounded = prod4_q + Half;
  assign step    = SUM_W'(rounded >>> FRAC_W);
  assign res     = RES_W'(y0_4_q) + RES_W'(step);

  always_comb begin
    if (beyond4_q) begin
      value_d = '0;
    end else if (!res[RES_W-1] && (|res[RES_W-2:DATA_W-1])) begin
      value_d = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (res[RES_W-1] && !(&res[RES_W-2:DATA_W-1])) begin
      value_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      value_d = DATA_W'(res);
    end
  end

  // Stage enables.
  assign en5     = !v5_q || out_ready_i;
  assign en4     = !v4_q || en5;
  assign ready_o = en4;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en4) begin
        v4_q <= ctl_i.valid;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
    end
  end

  // Stage payloads; stage 5 is the output register.
  always_ff @(posedge clk_i) begin
    if (en4 && ctl_i.valid) begin
      beyond4_q <= ctl_i.beyond;
      prod4_q   <= prod_d;
      y0_4_q    <= y0_i;
    end
    if (en5 && v4_q) begin
      beyond5_q <= beyond4_q;
      value5_q  <= value_d;
    end
  end

  assign out_valid_o    = v5_q;
  assign value_o        = value5_q;
  assign beyond_table_o = beyond5_q;

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pti_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_TYPES * (MAX_TYPES + 1) / 2 * MAX_VALUES;
  localparam int unsigned LATENCY     = 5;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam longint     SAT_HI      = 64'sd2147483647;
  localparam longint     SAT_LO      = -64'sd2147483648;
  // Index 3 decodes to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // One input item as it crosses the in channel.
  typedef struct packed {
    logic                     func;
    logic                     table_select;
    logic [TYPE_W-1:0]        type_a;
    logic [TYPE_W-1:0]        type_b;
    logic [DIST_W-1:0]        distance;
    logic [WIDX_W-1:0]        write_index;
    logic signed [DATA_W-1:0] write_value;
  } pti_item_t;

  // One interpolated lookup as it leaves on the out channel.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     beyond;
  } lookup_t;

  // Mirrors both tables and the registers, and predicts each lookup.
  class pti_scoreboard;
    int                 pot_tab[TABLE_DEPTH];
    int                 force_tab[TABLE_DEPTH];
    bit                 pot_set[TABLE_DEPTH];
    bit                 force_set[TABLE_DEPTH];
    logic [NTYPES_W-1:0]  num_types;
    logic [NVALUES_W-1:0] num_values;
    logic [STEP_W-1:0]    step_recip;
    lookup_t            pending_lookups[$];
    int unsigned        failures;

    function new();
      num_types  = NUM_TYPES_RST;
      num_values = NUM_VALUES_RST;
      step_recip = STEP_RECIP_RST;
      failures   = 0;
    endfunction

    function int unsigned eff_types();
      int unsigned t;
      t = num_types;
      if (t < 1) t = 1;
      if (t > MAX_TYPES) t = MAX_TYPES;
      return t;
    endfunction

    function int unsigned eff_values();
      int unsigned n;
      n = num_values;
      if (n < 2) n = 2;
      if (n > MAX_VALUES) n = MAX_VALUES;
      return n;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_NUM_TYPES:  num_types  = data[NTYPES_W-1:0];
        CFG_NUM_VALUES: num_values = data[NVALUES_W-1:0];
        CFG_STEP_RECIP: step_recip = data;
        default: ;
      endcase
    endfunction

    // Address of the lower sample a query reads, or -1 when it falls outside the table.
    function longint sample_addr(pti_item_t it);
      int unsigned       t, n, lo, hi, pair;
      logic [63:0]       prod;
      longint unsigned   sample, addr;
      t = eff_types();
      n = eff_values();
      lo = (it.type_a < it.type_b) ? it.type_a : it.type_b;
      hi = (it.type_a < it.type_b) ? it.type_b : it.type_a;
      prod = {32'd0, it.distance} * {32'd0, step_recip};
      sample = prod[63:32];
      if (hi >= t || sample + 1 >= n) return -1;
      pair = lo * (2 * t - lo + 1) / 2 + (hi - lo);
      addr = longint'(pair) * n + sample;
      if (addr + 1 >= TABLE_DEPTH) return -1;
      return longint'(addr);
    endfunction

    // Entry a query would read before any item wrote it, or -1 when there is none.
    function longint unwritten_entry(pti_item_t it);
      longint addr;
      bit     hit;
      if (it.func != FUNC_QUERY) return -1;
      addr = sample_addr(it);
      if (addr < 0) return -1;
      for (longint k = addr; k <= addr + 1; k++) begin
        hit = (it.table_select == TBL_FORCE) ? force_set[k] : pot_set[k];
        if (!hit) return k;
      end
      return -1;
    endfunction

    // Linear interpolation between the two samples around the scaled distance.
    function lookup_t interpolate(pti_item_t it);
      int unsigned       t, n, lo, hi, pair;
      logic [63:0]       prod;
      longint unsigned   sample, addr;
      longint            frac, y0, y1, q, r;
      lookup_t           res;
      t = eff_types();
      n = eff_values();
      lo = (it.type_a < it.type_b) ? it.type_a : it.type_b;
      hi = (it.type_a < it.type_b) ? it.type_b : it.type_a;
      prod = {32'd0, it.distance} * {32'd0, step_recip};
      sample = prod[63:32];
      frac = prod[31:16];
      res.value = '0;
      res.beyond = 1'b1;
      if (hi >= t || sample + 1 >= n) return res;
      pair = lo * (2 * t - lo + 1) / 2 + (hi - lo);
      addr = longint'(pair) * n + sample;
      if (addr + 1 >= TABLE_DEPTH) return res;
      if (it.table_select == TBL_FORCE) begin
        y0 = force_tab[addr];
        y1 = force_tab[addr + 1];
      end else begin
        y0 = pot_tab[addr];
        y1 = pot_tab[addr + 1];
      end
      // Arithmetic shift floors, which rounds ties toward plus infinity.
      q = ((y1 - y0) * frac + 32768) >>> 16;
      r = y0 + q;
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      res.value = r[31:0];
      res.beyond = 1'b0;
      return res;
    endfunction

    function void note_item(pti_item_t it);
      if (it.func == FUNC_WRITE) begin
        if (it.write_index < TABLE_DEPTH) begin
          if (it.table_select == TBL_FORCE) begin
            force_tab[it.write_index] = it.write_value;
            force_set[it.write_index] = 1'b1;
          end else begin
            pot_tab[it.write_index] = it.write_value;
            pot_set[it.write_index] = 1'b1;
          end
        end
      end else begin
        pending_lookups.push_back(interpolate(it));
      end
    endfunction

    function void check_result(logic signed [DATA_W-1:0] got_value, logic got_beyond);
      lookup_t want;
      if (pending_lookups.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: value %0d beyond %0b", got_value, got_beyond);
        return;
      end
      want = pending_lookups.pop_front();
      if (got_value !== want.value || got_beyond !== want.beyond) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected value %0d beyond %0b, got value %0d beyond %0b",
                   want.value, want.beyond, got_value, got_beyond);
      end
    endfunction

    function int unsigned pending();
      return pending_lookups.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     func_i;
  logic                     table_select_i;
  logic [TYPE_W-1:0]        type_a_i;
  logic [TYPE_W-1:0]        type_b_i;
  logic [DIST_W-1:0]        distance_i;
  logic [WIDX_W-1:0]        write_index_i;
  logic signed [DATA_W-1:0] write_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] value_o;
  logic                     beyond_table_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [DATA_W-1:0]        cfg_data_i;

  pti_scoreboard sb;
  bit            in_gaps_on;
  bit            rx_stalls_on;
  int unsigned   cycle_count = 0;
  int unsigned   items_sent = 0;

  pair_table_interpolator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .table_select_i (table_select_i),
    .type_a_i       (type_a_i),
    .type_b_i       (type_b_i),
    .distance_i     (distance_i),
    .write_index_i  (write_index_i),
    .write_value_i  (write_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_o        (value_o),
    .beyond_table_o (beyond_table_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: check every accepted result and stall at random when stalls are on.
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_result(value_o, beyond_table_o);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_stalls_on) stall_left = pick_gap();
      end
    end
  end

  // All fields random; callers override the ones that matter.
  function automatic pti_item_t noise_item();
    pti_item_t it;
    it.func         = 1'($urandom_range(0, 1));
    it.table_select = 1'($urandom_range(0, 1));
    it.type_a       = TYPE_W'($urandom_range(0, 7));
    it.type_b       = TYPE_W'($urandom_range(0, 7));
    it.distance     = $urandom();
    it.write_index  = WIDX_W'($urandom_range(0, (1 << WIDX_W) - 1));
    it.write_value  = $urandom();
    return it;
  endfunction

  function automatic pti_item_t make_write(logic sel, int unsigned addr, logic [31:0] val);
    pti_item_t it;
    it = noise_item();
    it.func = FUNC_WRITE;
    it.table_select = sel;
    it.write_index = WIDX_W'(addr);
    it.write_value = val;
    return it;
  endfunction

  function automatic pti_item_t make_query(logic sel, int unsigned a, int unsigned b,
                                           logic [31:0] distance);
    pti_item_t it;
    it = noise_item();
    it.func = FUNC_QUERY;
    it.table_select = sel;
    it.type_a = TYPE_W'(a);
    it.type_b = TYPE_W'(b);
    it.distance = distance;
    return it;
  endfunction

  // Distances aimed mostly at valid samples for the current step.
  function automatic logic [31:0] pick_distance(int unsigned n, logic [31:0] recip);
    int          roll;
    logic [63:0] target, d;
    roll = $urandom_range(0, 99);
    if (roll < 8 || recip == 0) return $urandom();
    if (roll < 12) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    target = {32'($urandom_range(0, n)), 32'($urandom())};
    d = target / {32'd0, recip};
    if (d[63:32] != 0) return $urandom();
    return d[31:0];
  endfunction

  function automatic pti_item_t random_item();
    pti_item_t   it;
    int unsigned t, n;
    it = noise_item();
    t = sb.eff_types();
    n = sb.eff_values();
    if ($urandom_range(0, 99) < 25) begin
      it.func = FUNC_WRITE;
      if ($urandom_range(0, 99) < 88)
        it.write_index = WIDX_W'($urandom_range(0, TABLE_DEPTH - 1));
      if ($urandom_range(0, 99) < 5)
        it.write_value = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end else begin
      it.func = FUNC_QUERY;
      if ($urandom_range(0, 99) < 85) begin
        it.type_a = TYPE_W'($urandom_range(0, t - 1));
        it.type_b = TYPE_W'($urandom_range(0, t - 1));
      end
      it.distance = pick_distance(n, sb.step_recip);
    end
    return it;
  endfunction

  task automatic send_item(input pti_item_t it);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= it.func;
    table_select_i <= it.table_select;
    type_a_i       <= it.type_a;
    type_b_i       <= it.type_b;
    distance_i     <= it.distance;
    write_index_i  <= it.write_index;
    write_value_i  <= it.write_value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(it);
    items_sent++;
  endtask

  // Write any entry a query would read that no item has written yet, then send it.
  task automatic send_filled(input pti_item_t it);
    longint missing;
    missing = sb.unwritten_entry(it);
    while (missing >= 0) begin
      send_item(make_write(it.table_select, 32'(missing), $urandom()));
      missing = sb.unwritten_entry(it);
    end
    send_item(it);
  endtask

  // Wait until every lookup has come back and the pipeline has emptied.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  // Write all three registers back to back, optionally also the unused index.
  task automatic set_config(input logic [31:0] types_word, input logic [31:0] values_word,
                            input logic [31:0] recip_word, input bit poke_unused);
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
    int                   last;
    last = poke_unused ? 3 : 2;
    for (int k = 0; k <= last; k++) begin
      case (k)
        0: begin idx = CFG_NUM_TYPES;  data = types_word;  end
        1: begin idx = CFG_NUM_VALUES; data = values_word; end
        2: begin idx = CFG_STEP_RECIP; data = recip_word;  end
        default: begin idx = CFG_UNUSED_IDX; data = $urandom(); end
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.set_reg(idx, data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count, input bit gaps, input bit stalls);
    int unsigned stop;
    stop = items_sent + count;
    in_gaps_on = gaps;
    rx_stalls_on = stalls;
    while (items_sent < stop) begin
      send_filled(random_item());
      // Now and then let the pipeline run dry in the middle of a batch.
      if ($urandom_range(0, 99) < 2) drain();
    end
    drain();
  endtask

  initial begin
    logic [31:0] probe;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_WRITE;
    table_select_i = TBL_POT;
    type_a_i       = '0;
    type_b_i       = '0;
    distance_i     = '0;
    write_index_i  = '0;
    write_value_i  = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_NUM_TYPES;
    cfg_data_i     = '0;
    in_gaps_on     = 1'b0;
    rx_stalls_on   = 1'b0;
    sb = new();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset settings: one distance unit per sample.
    in_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    send_item(make_write(TBL_POT, 0, 32'h7FFF_FFFF));
    send_item(make_write(TBL_POT, 1, 32'h8000_0000));
    send_filled(make_query(TBL_POT, 0, 0, 32'h0));
    send_filled(make_query(TBL_POT, 0, 0, 32'h0000_8000));
    send_item(make_write(TBL_FORCE, 0, 32'h8000_0000));
    send_item(make_write(TBL_FORCE, 1, 32'h7FFF_FFFF));
    send_filled(make_query(TBL_FORCE, 0, 0, 32'h0000_FFFF));
    // Rounding ties, upward and downward slope.
    send_item(make_write(TBL_POT, 2, 32'd0));
    send_item(make_write(TBL_POT, 3, 32'd1));
    send_filled(make_query(TBL_POT, 0, 0, 32'h0002_8000));
    send_item(make_write(TBL_POT, 4, 32'd0));
    send_item(make_write(TBL_POT, 5, 32'hFFFF_FFFF));
    send_filled(make_query(TBL_POT, 0, 0, 32'h0004_8000));
    // Last entry, then writes past the end that must be dropped.
    send_item(make_write(TBL_FORCE, TABLE_DEPTH - 1, $urandom()));
    send_item(make_write(TBL_FORCE, TABLE_DEPTH, $urandom()));
    send_item(make_write(TBL_FORCE, (1 << WIDX_W) - 1, $urandom()));
    send_filled(make_query(TBL_FORCE, 7, 7, 32'h00FE_FFFF));
    // Swapped types must land on the same pair.
    probe = {16'($urandom_range(0, 253)), 16'($urandom())};
    send_filled(make_query(TBL_POT, 5, 3, probe));
    send_filled(make_query(TBL_POT, 3, 5, probe));
    // Past the last sample, the largest distance and the smallest nonzero one.
    send_filled(make_query(TBL_POT, 2, 2, 32'h00FF_0000));
    send_filled(make_query(TBL_FORCE, 1, 6, 32'hFFFF_FFFF));
    send_filled(make_query(TBL_POT, 0, 7, 32'h0000_0001));
    run_random(230, 1'b1, 1'b1);

    // Smallest layout: one type, two samples.
    set_config(32'd1, 32'd2, 32'd65536, 1'b0);
    run_random(150, 1'b0, 1'b0);

    // All zero: both counts clamp up and every distance maps to sample 0.
    set_config(32'd0, 32'd0, 32'd0, 1'b1);
    run_random(100, 1'b1, 1'b0);

    // Upper bits set and counts above the maximum clamp down.
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    run_random(150, 1'b0, 1'b1);

    // Smallest nonzero step reciprocal.
    set_config(32'd8, 32'd256, 32'd1, 1'b0);
    run_random(150, 1'b1, 1'b1);

    // Random settings.
    for (int ph = 0; ph < 4; ph++) begin
      set_config($urandom_range(1, 8), $urandom_range(2, 256),
                 ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1 << 10, 1 << 22),
                 ph == 0);
      run_random(255, ph[0], ph[1]);
    end

    drain();
    if (sb.failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pti_pkg.sv
hw/rtl/pti_ram.sv
hw/rtl/pti_addr.sv
hw/rtl/pti_interp.sv
hw/rtl/pair_table_interpolator.sv
sim/tb.sv
